// File: sv/tsse_pkg.sv
// Shared types, constants and register clamping helpers for the spike snippet extractor.
`default_nettype none

package tsse_pkg;

  localparam int NUM_CH        = 4;
  localparam int CH_IDX_W      = 2;
  localparam int SAMPLE_W      = 16;
  localparam int WORD_W        = NUM_CH * SAMPLE_W;
  localparam int THR_W         = 15;
  localparam int TIME_W        = 48;
  localparam int ROW_W         = 6;
  localparam int LEN_W         = 7;
  localparam int PRE_W         = 5;
  localparam int POST_W        = 6;
  localparam int CNT_W         = 3;
  localparam int MASK_W        = 4;
  localparam int SST_W         = 7;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 15;

  localparam int MAX_CHANNELS  = 4;
  localparam int CH_LIMIT      = (MAX_CHANNELS < NUM_CH) ? MAX_CHANNELS : NUM_CH;
  localparam int MAX_PRE       = 16;
  localparam int MAX_POST      = 48;
  localparam int WINDOW_DEPTH_DEFAULT = 64;

  localparam logic [SAMPLE_W-1:0] OFFSET_BIN = 16'h8000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THR0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POST  = 3'd7;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] word_t;

  // Clamped register view used by the datapath.
  typedef struct packed {
    logic [NUM_CH-1:0][THR_W-1:0] thr;
    logic [NUM_CH-1:0]            lane_on;
    logic [PRE_W-1:0]             pre;
    logic [POST_W-1:0]            post;
  } cfg_t;

  // Snippet request from the detector to the row sequencer.
  typedef struct packed {
    logic              go;
    logic [TIME_W-1:0] peak_time;
    logic [PRE_W-1:0]  pre;
    logic [LEN_W-1:0]  len;
  } emit_req_t;

  // One snippet row as it leaves the block.
  typedef struct packed {
    logic [TIME_W-1:0] peak_time;
    logic [ROW_W-1:0]  row_index;
    word_t             wave;
    logic              last_row;
  } row_t;

  function automatic logic [CNT_W-1:0] held_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (r == '0) r = CNT_W'(1);
    if (r > CNT_W'(CH_LIMIT)) r = CNT_W'(CH_LIMIT);
    return r;
  endfunction

  function automatic logic [NUM_CH-1:0] lane_enable(input logic [MASK_W-1:0] mask,
                                                    input logic [CNT_W-1:0] cnt);
    logic [NUM_CH-1:0] en;
    for (int i = 0; i < NUM_CH; i++) begin
      en[i] = mask[i] && (CNT_W'(i) < cnt);
    end
    return en;
  endfunction

  function automatic logic [PRE_W-1:0] held_pre(input logic [PRE_W-1:0] p, input int depth);
    logic [PRE_W-1:0] r;
    int               lim;
    lim = depth - 2;
    r = p;
    if (r == '0) r = PRE_W'(1);
    if (r > PRE_W'(MAX_PRE)) r = PRE_W'(MAX_PRE);
    if (int'(r) > lim) r = PRE_W'(lim);
    return r;
  endfunction

  function automatic logic [POST_W-1:0] held_post(input logic [POST_W-1:0] q,
                                                  input logic [PRE_W-1:0] pre,
                                                  input int depth);
    logic [POST_W-1:0] r;
    int                lim;
    lim = depth - int'(pre);
    r = q;
    if (r == '0) r = POST_W'(1);
    if (r > POST_W'(MAX_POST)) r = POST_W'(MAX_POST);
    if (int'(r) > lim) r = POST_W'(lim);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/tsse_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module tsse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: sv/tsse_hist.sv
// Sample history: RAM plus per-entry valid bits so unwritten entries read as zero.
`default_nettype none

module tsse_hist
  import tsse_pkg::*;
#(
  parameter int DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire word_t                    wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output word_t                         rd_data
);

  logic [DEPTH-1:0]  vld;
  logic              vld_q;
  logic [WORD_W-1:0] ram_q;

  tsse_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      vld_q <= vld[rd_addr];
    end
  end

  assign rd_data = ram_q & {WORD_W{vld_q}};

endmodule

`default_nettype wire

// File: sv/tsse_detect.sv
// Trigger and peak tracking state machine; raises a snippet request when a window is complete.
`default_nettype none

module tsse_detect
  import tsse_pkg::*;
#(
  parameter int DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     fire,
  input  wire word_t                    samples,
  input  wire cfg_t                     cfg,
  output logic      [$clog2(DEPTH)-1:0] wp,
  output emit_req_t                     req,
  output logic      [$clog2(DEPTH)-1:0] req_slot
);

  localparam int AW = $clog2(DEPTH);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PEAK = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;

  logic [1:0]          phase, phase_next;
  logic [CH_IDX_W-1:0] tc, tc_next;
  logic [SAMPLE_W-1:0] pv, pv_next;
  logic [SST_W-1:0]    sst, sst_next;
  logic [TIME_W-1:0]   pt, pt_next;
  logic [AW-1:0]       ps, ps_next;
  logic [TIME_W-1:0]   count;

  logic [NUM_CH-1:0]   hit;
  logic                any_hit;
  logic [CH_IDX_W-1:0] first_ch;

  // Negated sample against threshold, one comparator per channel.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      hit[c] = cfg.lane_on[c] &&
               ($signed(-{{2{samples[c][SAMPLE_W-1]}}, samples[c]}) >
                $signed({3'b000, cfg.thr[c]}));
    end
  end

  always_comb begin
    first_ch = '0;
    for (int c = NUM_CH - 1; c >= 0; c--) begin
      if (hit[c]) first_ch = CH_IDX_W'(c);
    end
  end

  assign any_hit = |hit;

  always_comb begin
    logic [SAMPLE_W-1:0] x;
    logic [SST_W-1:0]    sst_inc;
    logic [TIME_W-1:0]   peak_gap;
    logic [POST_W-1:0]   post_m1;
    x          = samples[tc];
    sst_inc    = sst + SST_W'(1);
    post_m1    = cfg.post - POST_W'(1);
    phase_next = phase;
    tc_next    = tc;
    pv_next    = pv;
    sst_next   = sst;
    pt_next    = pt;
    ps_next    = ps;
    req        = '0;
    req_slot   = ps;

    case (phase)
      PH_PEAK: begin
        // Follow the falling run, capped at post samples after the trigger.
        if ((sst < SST_W'(cfg.post)) && ($signed(x) < $signed(pv))) begin
          pv_next    = x;
          pt_next    = count;
          ps_next    = wp;
          sst_next   = sst_inc;
          phase_next = (sst_inc >= SST_W'(cfg.post)) ? PH_WAIT : PH_PEAK;
        end else begin
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
      end
      default: begin
        phase_next = PH_IDLE;
        if (any_hit) begin
          tc_next    = first_ch;
          pv_next    = samples[first_ch];
          pt_next    = count;
          ps_next    = wp;
          sst_next   = '0;
          phase_next = PH_PEAK;
        end
      end
    endcase

    peak_gap = count - pt_next;
    if ((phase_next == PH_WAIT) && (peak_gap >= TIME_W'(post_m1))) begin
      req.go        = fire;
      req.peak_time = pt_next;
      req.pre       = cfg.pre;
      req.len       = LEN_W'(cfg.pre) + LEN_W'(cfg.post);
      req_slot      = ps_next;
      phase_next    = PH_IDLE;
      // A window that closed late lets this same sample start a new spike.
      if ((peak_gap >= TIME_W'(cfg.post)) && any_hit) begin
        tc_next    = first_ch;
        pv_next    = samples[first_ch];
        pt_next    = count;
        ps_next    = wp;
        sst_next   = '0;
        phase_next = PH_PEAK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tc    <= '0;
      pv    <= '0;
      sst   <= '0;
      pt    <= '0;
      ps    <= '0;
      count <= '0;
      wp    <= '0;
    end else if (fire) begin
      phase <= phase_next;
      tc    <= tc_next;
      pv    <= pv_next;
      sst   <= sst_next;
      pt    <= pt_next;
      ps    <= ps_next;
      count <= count + TIME_W'(1);
      wp    <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
    end
  end

endmodule

`default_nettype wire

// File: sv/tsse_emit.sv
// Row sequencer: reads the snippet window from history and streams rows through a two-deep output.
`default_nettype none

module tsse_emit
  import tsse_pkg::*;
#(
  parameter int DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire emit_req_t                req,
  input  wire logic [$clog2(DEPTH)-1:0] req_slot,
  input  wire logic [NUM_CH-1:0]        lane_on,
  output logic      [$clog2(DEPTH)-1:0] rd_addr,
  input  wire word_t                    rd_data,
  output logic                          busy,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output row_t                          out_row
);

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0]     slot;
  logic [ROW_W-1:0]  k;
  logic [LEN_W-1:0]  len;
  logic [TIME_W-1:0] pt;
  logic [AW:0]       start_ext;
  logic [AW:0]       pre_ext;
  logic [AW-1:0]     start;
  logic              is_last;

  logic              f_v, o_v, s_v;
  logic [ROW_W-1:0]  f_k;
  logic              f_last;
  row_t              o_row, s_row, land;
  logic              pop, o_free, issue;
  logic [1:0]        occ, occ_after;

  // First slot of the window, peak slot minus pre, modulo the depth.
  assign pre_ext   = (AW + 1)'(req.pre);
  assign start_ext = ({1'b0, req_slot} >= pre_ext) ? ({1'b0, req_slot} - pre_ext)
                                                   : ({1'b0, req_slot} + (AW + 1)'(DEPTH)
                                                      - pre_ext);
  assign start     = start_ext[AW-1:0];

  assign is_last   = (LEN_W'(k) + LEN_W'(1)) == len;
  assign rd_addr   = slot;

  assign pop       = o_v && out_ready;
  assign o_free    = !o_v || pop;
  assign occ       = {1'b0, o_v} + {1'b0, s_v} + {1'b0, f_v};
  assign occ_after = occ - {1'b0, pop};
  assign issue     = busy && (occ_after < 2'd2);

  always_comb begin
    land.peak_time = pt;
    land.row_index = f_k;
    land.last_row  = f_last;
    for (int c = 0; c < NUM_CH; c++) begin
      land.wave[c] = lane_on[c] ? SAMPLE_W'(rd_data[c] + OFFSET_BIN) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      f_v  <= 1'b0;
      o_v  <= 1'b0;
      s_v  <= 1'b0;
    end else begin
      if (req.go) begin
        busy <= 1'b1;
      end else if (issue && is_last) begin
        busy <= 1'b0;
      end
      f_v <= issue;
      if (o_free) begin
        if (s_v) begin
          o_v <= 1'b1;
          s_v <= f_v;
        end else begin
          o_v <= f_v;
          s_v <= 1'b0;
        end
      end else if (f_v) begin
        s_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      slot <= start;
      k    <= '0;
      len  <= req.len;
      pt   <= req.peak_time;
    end else if (issue) begin
      slot <= (slot == AW'(DEPTH - 1)) ? '0 : slot + AW'(1);
      k    <= k + ROW_W'(1);
    end
    if (issue) begin
      f_k    <= k;
      f_last <= is_last;
    end
    if (o_free) begin
      if (s_v) begin
        o_row <= s_row;
      end else if (f_v) begin
        o_row <= land;
      end
      if (s_v && f_v) begin
        s_row <= land;
      end
    end else if (f_v) begin
      s_row <= land;
    end
  end

  assign out_valid = o_v;
  assign out_row   = o_row;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) s_v |-> o_v)
    else $error("skid entry holds a row while the output register is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(o_v && s_v && f_v))
    else $error("row read in flight with no room to land");

  a_req_when_free: assert property (@(posedge clk) disable iff (rst) req.go |-> !busy)
    else $error("snippet request while rows are still being read");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
                                      (f_v && f_last) |-> !busy)
    else $error("sequencer still busy after reading the final row");

endmodule

`default_nettype wire

// File: sv/threshold_spike_snippet_extractor_core.sv
// Top level of the threshold spike snippet extractor: registers, history, detector, sequencer.
`default_nettype none

// Usage
// The input channel carries one beat per sample time: sample_ch0..sample_ch3, signed counts,
// accepted when in_valid and in_ready are both high. Each beat is written into a history RAM
// and updates the trigger/peak detector in the same cycle. A beat that causes no snippet leaves
// in_ready high for the next one.
// When a beat completes a snippet window, in_ready drops and the row sequencer reads the
// window from the history RAM, oldest row first, one row per cycle while the output buffer has
// room, through its single read port. The first row passes the registered RAM read and then
// the output register before it appears on the output channel; in_ready stays low until the
// last of the pre+post rows has been read. Each row beat carries peak_time, row_index, the four
// offset-binary waves and last_row, and is taken when out_valid and out_ready are high.
// The output has a two-row buffer: when out_ready is low the sequencer stops reading after
// two rows are held, and nothing is lost. Input beats are taken again as soon as all rows of
// a snippet have been read, even while the last rows still wait at the output.
// Registers are written through cfg_we / cfg_index / cfg_data with no wait; write them only
// when no snippet is pending. Synchronous reset restores the register defaults, clears the
// detector, the sample counter and the history valid bits, so history reads back as zero.

module threshold_spike_snippet_extractor_core
  import tsse_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    sample_ch0,
  input  wire logic signed [15:0]    sample_ch1,
  input  wire logic signed [15:0]    sample_ch2,
  input  wire logic signed [15:0]    sample_ch3,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [TIME_W-1:0]          peak_time,
  output logic [ROW_W-1:0]           row_index,
  output logic [SAMPLE_W-1:0]        wave_ch0,
  output logic [SAMPLE_W-1:0]        wave_ch1,
  output logic [SAMPLE_W-1:0]        wave_ch2,
  output logic [SAMPLE_W-1:0]        wave_ch3,
  output logic                       last_row
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  // Configuration registers as written.
  logic [NUM_CH-1:0][THR_W-1:0] thr;
  logic [MASK_W-1:0]            mask;
  logic [CNT_W-1:0]             ch_count;
  logic [PRE_W-1:0]             pre;
  logic [POST_W-1:0]            post;

  cfg_t      cfg;
  word_t     word;
  word_t     rd_data;
  emit_req_t req;
  logic      fire;
  logic      busy;
  row_t      out_row;
  logic [AW-1:0] wp;
  logic [AW-1:0] req_slot;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        thr[c] <= THR_W'(256);
      end
      mask     <= MASK_W'(15);
      ch_count <= CNT_W'(4);
      pre      <= PRE_W'(8);
      post     <= POST_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THR0:  thr[0]   <= cfg_data;
        REG_THR1:  thr[1]   <= cfg_data;
        REG_THR2:  thr[2]   <= cfg_data;
        REG_THR3:  thr[3]   <= cfg_data;
        REG_MASK:  mask     <= cfg_data[MASK_W-1:0];
        REG_COUNT: ch_count <= cfg_data[CNT_W-1:0];
        REG_PRE:   pre      <= cfg_data[PRE_W-1:0];
        REG_POST:  post     <= cfg_data[POST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The datapath sees the clamped register values; post is limited so the window fits.
  always_comb begin
    cfg.thr     = thr;
    cfg.lane_on = lane_enable(mask, held_count(ch_count));
    cfg.pre     = held_pre(pre, WINDOW_DEPTH);
    cfg.post    = held_post(post, cfg.pre, WINDOW_DEPTH);
  end

  assign word     = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};
  assign in_ready = !busy;
  assign fire     = in_valid && in_ready;

  tsse_hist #(
    .DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fire),
    .wr_addr(wp),
    .wr_data(word),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  tsse_detect #(
    .DEPTH(WINDOW_DEPTH)
  ) u_detect (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .samples (word),
    .cfg     (cfg),
    .wp      (wp),
    .req     (req),
    .req_slot(req_slot)
  );

  tsse_emit #(
    .DEPTH(WINDOW_DEPTH)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_slot (req_slot),
    .lane_on  (cfg.lane_on),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_row  (out_row)
  );

  assign peak_time = out_row.peak_time;
  assign row_index = out_row.row_index;
  assign wave_ch0  = out_row.wave[0];
  assign wave_ch1  = out_row.wave[1];
  assign wave_ch2  = out_row.wave[2];
  assign wave_ch3  = out_row.wave[3];
  assign last_row  = out_row.last_row;

endmodule

`default_nettype wire
